[src/rwcm_pkg.sv]
package rwcm_pkg;

    localparam int COORD_BITS = 12;
    localparam int PIXEL_BITS = 16;
    localparam int LABEL_BITS = 16;

    localparam int PIX_W      = 16;
    localparam int LAB_W      = 16;
    localparam int ROI_W      = 12;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    localparam int TOT_W  = 40;
    localparam int S1_W   = 52;
    localparam int S2_W   = 64;
    localparam int MEAN_W = 20;
    localparam int VAR_W  = 32;
    localparam int FRAC_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_MASK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COL_MIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COL_MAX    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_MIN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_MAX    = 3'd6;

    // products of the shared multiplier
    localparam int XW_W    = COORD_BITS + PIXEL_BITS;
    localparam int XXW_W   = XW_W + COORD_BITS;
    localparam int MUL_A_W = (XW_W > MEAN_W) ? XW_W : MEAN_W;
    localparam int MUL_B0  = (COORD_BITS > PIXEL_BITS) ? COORD_BITS : PIXEL_BITS;
    localparam int MUL_B_W = (MUL_B0 > MEAN_W) ? MUL_B0 : MEAN_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // divider: numerator scaled by 2^FRAC_W
    localparam int DIV_NUM_W = S2_W;
    localparam int DIV_DEN_W = TOT_W;
    localparam int DIV_Q_W   = DIV_NUM_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W);

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[src/rwcm_intf.sv]
interface rwcm_pix_if;
    import rwcm_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_value;
    logic [LAB_W-1:0] pixel_label;
    modport source (output valid, pixel_value, pixel_label, input ready);
    modport sink   (input valid, pixel_value, pixel_label, output ready);
endinterface

interface rwcm_res_if;
    import rwcm_pkg::*;
    logic              valid;
    logic              ready;
    logic [TOT_W-1:0]  intensity_total;
    logic [MEAN_W-1:0] centroid_col;
    logic [MEAN_W-1:0] centroid_row;
    logic [VAR_W-1:0]  variance_col;
    logic [VAR_W-1:0]  variance_row;
    logic              stats_valid;
    modport source (output valid, intensity_total, centroid_col, centroid_row,
                    variance_col, variance_row, stats_valid, input ready);
    modport sink   (input valid, intensity_total, centroid_col, centroid_row,
                    variance_col, variance_row, stats_valid, output ready);
endinterface

[src/rwcm_mul.sv]
module rwcm_mul (
    input  logic                          clk,
    input  logic [rwcm_pkg::MUL_A_W-1:0]  a,
    input  logic [rwcm_pkg::MUL_B_W-1:0]  b,
    output logic [rwcm_pkg::MUL_P_W-1:0]  prod
);
    import rwcm_pkg::*;

    logic [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign prod = prod_reg;

endmodule

[src/rwcm_div.sv]
module rwcm_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [rwcm_pkg::DIV_NUM_W-1:0]  num,
    input  logic [rwcm_pkg::DIV_DEN_W-1:0]  den,
    output rwcm_pkg::div_stat_t             stat,
    output logic [rwcm_pkg::DIV_NUM_W-1:0]  quo
);
    import rwcm_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_Q_W-1:0]   shift_reg;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;
    logic [DIV_DEN_W-1:0] rem_next;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        trial    = {rem_reg, shift_reg[DIV_Q_W-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_Q_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= {num, {FRAC_W{1'b0}}};
            rem_reg   <= '0;
            den_reg   <= den;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[DIV_Q_W-2:0], ge};
            rem_reg   <= rem_next;
        end
    end

    // saturate the scaled quotient to the numerator width
    assign quo = (|shift_reg[DIV_Q_W-1:DIV_NUM_W]) ? '1 : shift_reg[DIV_NUM_W-1:0];

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[src/roi_weighted_centroid_moments_unit.sv]
// counted pixel: S_XW, S_XXW, S_YW, S_YYW, S_ACC (shared multiplier runs four products)
// region end: four 72-step divisions in the shared divider
// plus one multiplier pass per axis for the squared mean
// the next region's pixels are taken while its result waits in the output register
// reset (asynchronous, active low): config and counters to zero, accumulators cleared
module roi_weighted_centroid_moments_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rwcm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rwcm_pkg::CFG_DATA_W-1:0]  cfg_data,
    rwcm_pix_if.sink                         pix,
    rwcm_res_if.source                       res
);
    import rwcm_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_XW   = 4'd1;
    localparam logic [3:0] S_XXW  = 4'd2;
    localparam logic [3:0] S_YW   = 4'd3;
    localparam logic [3:0] S_YYW  = 4'd4;
    localparam logic [3:0] S_ACC  = 4'd5;
    localparam logic [3:0] S_FIN  = 4'd6;
    localparam logic [3:0] S_DM   = 4'd7;
    localparam logic [3:0] S_DV   = 4'd8;
    localparam logic [3:0] S_SQ   = 4'd9;
    localparam logic [3:0] S_LOAD = 4'd10;

    logic [3:0] state_reg, state_next;

    logic [PIX_W-1:0] bg_reg;
    logic             mask_reg;
    logic [LAB_W-1:0] tgt_reg;
    logic [ROI_W-1:0] cmin_reg, cmax_reg, rmin_reg, rmax_reg;

    logic [COORD_BITS-1:0] col_reg, row_reg, x_reg, y_reg;
    logic [PIXEL_BITS-1:0] w_reg;
    logic                  last_reg;

    logic [TOT_W-1:0] sum_int_reg;
    logic [S1_W-1:0]  sum_c_reg, sum_r_reg;
    logic [S2_W-1:0]  sum_cc_reg, sum_rr_reg;

    logic [XW_W-1:0]  xw_reg, yw_reg;
    logic [XXW_W-1:0] xxw_reg;

    logic              axis_reg;
    logic [MEAN_W-1:0] m_reg, cmean_reg, rmean_reg;
    logic [S2_W-1:0]   m2_reg;
    logic [VAR_W-1:0]  cvar_reg, rvar_reg;

    logic              res_valid_reg;
    logic [TOT_W-1:0]  res_tot_reg;
    logic [MEAN_W-1:0] res_cmean_reg, res_rmean_reg;
    logic [VAR_W-1:0]  res_cvar_reg, res_rvar_reg;
    logic              res_flag_reg;

    logic [PIXEL_BITS-1:0] pix_v;
    logic [PIX_W-1:0]      pix_ext;
    logic [LABEL_BITS-1:0] lab_v, tgt_v;
    logic [PIXEL_BITS-1:0] w_in;
    logic                  counted, row_end, last, accept;
    logic [COORD_BITS-1:0] cmin_c, cmax_c, rmin_c, rmax_c;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] prod;

    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_NUM_W-1:0] quo;
    div_stat_t            dstat;

    logic [TOT_W:0] int_add;
    logic [S1_W:0]  c_add, r_add;
    logic [S2_W:0]  cc_add, rr_add;

    logic [MEAN_W-1:0] m_clamp;
    logic [VAR_W-1:0]  sq;
    logic [S2_W-1:0]   var_full;
    logic [VAR_W-1:0]  var_sat;

    logic load_ok, bound_wr, restart;
    logic [COORD_BITS-1:0] cfg_coord;

    rwcm_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    rwcm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (sum_int_reg),
        .stat  (dstat),
        .quo   (quo)
    );

    always_comb
    begin
        cmin_c  = COORD_BITS'(cmin_reg);
        cmax_c  = COORD_BITS'(cmax_reg);
        rmin_c  = COORD_BITS'(rmin_reg);
        rmax_c  = COORD_BITS'(rmax_reg);
        pix_v   = PIXEL_BITS'(pix.pixel_value);
        pix_ext = PIX_W'(pix_v);
        lab_v   = LABEL_BITS'(pix.pixel_label);
        tgt_v   = LABEL_BITS'(tgt_reg);
        w_in    = PIXEL_BITS'(pix_ext - bg_reg);
        counted = (!mask_reg || (lab_v == tgt_v)) && (pix_ext > bg_reg);
        row_end = col_reg >= cmax_c;
        last    = row_end && (row_reg >= rmax_c);
        accept  = pix.valid && pix.ready;
    end

    // saturating accumulate, carry out means clamp
    always_comb
    begin
        int_add = {1'b0, sum_int_reg} + (TOT_W + 1)'(w_reg);
        c_add   = {1'b0, sum_c_reg} + (S1_W + 1)'(xw_reg);
        r_add   = {1'b0, sum_r_reg} + (S1_W + 1)'(yw_reg);
        cc_add  = {1'b0, sum_cc_reg} + (S2_W + 1)'(xxw_reg);
        rr_add  = {1'b0, sum_rr_reg} + (S2_W + 1)'(prod[XXW_W-1:0]);
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_XW:
            begin
                mul_a = MUL_A_W'(x_reg);
                mul_b = MUL_B_W'(w_reg);
            end
            S_XXW:
            begin
                mul_a = MUL_A_W'(prod[XW_W-1:0]);
                mul_b = MUL_B_W'(x_reg);
            end
            S_YW:
            begin
                mul_a = MUL_A_W'(y_reg);
                mul_b = MUL_B_W'(w_reg);
            end
            S_YYW:
            begin
                mul_a = MUL_A_W'(prod[XW_W-1:0]);
                mul_b = MUL_B_W'(y_reg);
            end
            S_DV:
            begin
                mul_a = MUL_A_W'(m_reg);
                mul_b = MUL_B_W'(m_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        div_start = ((state_reg == S_FIN) && (sum_int_reg != '0))
                 || ((state_reg == S_DM) && dstat.done)
                 || ((state_reg == S_SQ) && !axis_reg);
        unique case (state_reg)
            S_FIN:   div_num = DIV_NUM_W'(sum_c_reg);
            S_DM:    div_num = axis_reg ? sum_rr_reg : sum_cc_reg;
            S_SQ:    div_num = DIV_NUM_W'(sum_r_reg);
            default: div_num = '0;
        endcase
    end

    // variance = mean of squares minus floor(m*m / 256), clamped at zero
    always_comb
    begin
        m_clamp  = (|quo[DIV_NUM_W-1:MEAN_W]) ? '1 : quo[MEAN_W-1:0];
        sq       = prod[2*MEAN_W-1:FRAC_W];
        var_full = (m2_reg > S2_W'(sq)) ? (m2_reg - S2_W'(sq)) : '0;
        var_sat  = (|var_full[S2_W-1:VAR_W]) ? '1 : var_full[VAR_W-1:0];
    end

    always_comb
    begin
        load_ok   = (state_reg == S_LOAD) && (!res_valid_reg || res.ready);
        bound_wr  = cfg_we && ((cfg_index == REG_COL_MIN) || (cfg_index == REG_COL_MAX)
                            || (cfg_index == REG_ROW_MIN) || (cfg_index == REG_ROW_MAX));
        restart   = load_ok || bound_wr;
        cfg_coord = COORD_BITS'(cfg_data[ROI_W-1:0]);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (counted)
                        state_next = S_XW;
                    else if (last)
                        state_next = S_FIN;
                end
            end
            S_XW:  state_next = S_XXW;
            S_XXW: state_next = S_YW;
            S_YW:  state_next = S_YYW;
            S_YYW: state_next = S_ACC;
            S_ACC: state_next = last_reg ? S_FIN : S_IDLE;
            S_FIN: state_next = (sum_int_reg != '0) ? S_DM : S_LOAD;
            S_DM:
            begin
                if (dstat.done)
                    state_next = S_DV;
            end
            S_DV:
            begin
                if (dstat.done)
                    state_next = S_SQ;
            end
            S_SQ:   state_next = axis_reg ? S_LOAD : S_DM;
            S_LOAD:
            begin
                if (load_ok)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bg_reg        <= '0;
            mask_reg      <= 1'b0;
            tgt_reg       <= '0;
            cmin_reg      <= '0;
            cmax_reg      <= '0;
            rmin_reg      <= '0;
            rmax_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            sum_int_reg   <= '0;
            sum_c_reg     <= '0;
            sum_r_reg     <= '0;
            sum_cc_reg    <= '0;
            sum_rr_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BACKGROUND: bg_reg   <= cfg_data;
                    REG_USE_MASK:   mask_reg <= cfg_data[0];
                    REG_TARGET:     tgt_reg  <= cfg_data;
                    REG_COL_MIN:    cmin_reg <= cfg_data[ROI_W-1:0];
                    REG_COL_MAX:    cmax_reg <= cfg_data[ROI_W-1:0];
                    REG_ROW_MIN:    rmin_reg <= cfg_data[ROI_W-1:0];
                    REG_ROW_MAX:    rmax_reg <= cfg_data[ROI_W-1:0];
                    default:        ;
                endcase
            end

            // raster position; a bound write reloads from the new minimums
            if (bound_wr)
            begin
                col_reg <= (cfg_index == REG_COL_MIN) ? cfg_coord : cmin_c;
                row_reg <= (cfg_index == REG_ROW_MIN) ? cfg_coord : rmin_c;
            end
            else if (accept)
            begin
                if (last)
                begin
                    col_reg <= cmin_c;
                    row_reg <= rmin_c;
                end
                else if (row_end)
                begin
                    col_reg <= cmin_c;
                    row_reg <= row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end

            if (restart)
            begin
                sum_int_reg <= '0;
                sum_c_reg   <= '0;
                sum_r_reg   <= '0;
                sum_cc_reg  <= '0;
                sum_rr_reg  <= '0;
            end
            else if (state_reg == S_ACC)
            begin
                sum_int_reg <= int_add[TOT_W] ? '1 : int_add[TOT_W-1:0];
                sum_c_reg   <= c_add[S1_W] ? '1 : c_add[S1_W-1:0];
                sum_r_reg   <= r_add[S1_W] ? '1 : r_add[S1_W-1:0];
                sum_cc_reg  <= cc_add[S2_W] ? '1 : cc_add[S2_W-1:0];
                sum_rr_reg  <= rr_add[S2_W] ? '1 : rr_add[S2_W-1:0];
            end

            if (load_ok)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= col_reg;
            y_reg    <= row_reg;
            w_reg    <= w_in;
            last_reg <= last;
        end

        unique case (state_reg)
            S_XXW: xw_reg  <= prod[XW_W-1:0];
            S_YW:  xxw_reg <= prod[XXW_W-1:0];
            S_YYW: yw_reg  <= prod[XW_W-1:0];
            S_FIN: axis_reg <= 1'b0;
            S_DM:
            begin
                if (dstat.done)
                    m_reg <= m_clamp;
            end
            S_DV:
            begin
                if (dstat.done)
                    m2_reg <= quo;
            end
            S_SQ:
            begin
                if (axis_reg)
                begin
                    rmean_reg <= m_reg;
                    rvar_reg  <= var_sat;
                end
                else
                begin
                    cmean_reg <= m_reg;
                    cvar_reg  <= var_sat;
                    axis_reg  <= 1'b1;
                end
            end
            default: ;
        endcase

        if (load_ok)
        begin
            res_tot_reg  <= sum_int_reg;
            res_flag_reg <= sum_int_reg != '0;
            if (sum_int_reg != '0)
            begin
                res_cmean_reg <= cmean_reg;
                res_rmean_reg <= rmean_reg;
                res_cvar_reg  <= cvar_reg;
                res_rvar_reg  <= rvar_reg;
            end
            else
            begin
                res_cmean_reg <= '0;
                res_rmean_reg <= '0;
                res_cvar_reg  <= '0;
                res_rvar_reg  <= '0;
            end
        end
    end

    assign pix.ready           = (state_reg == S_IDLE);
    assign res.valid           = res_valid_reg;
    assign res.intensity_total = res_tot_reg;
    assign res.centroid_col    = res_cmean_reg;
    assign res.centroid_row    = res_rmean_reg;
    assign res.variance_col    = res_cvar_reg;
    assign res.variance_row    = res_rvar_reg;
    assign res.stats_valid     = res_flag_reg;

    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        dstat.busy |-> !pix.ready)
        else $error("pixel request taken while divider busy");

    a_done_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        dstat.done |-> (state_reg == S_DM || state_reg == S_DV))
        else $error("divider finished outside a division step");

    a_load_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        load_ok |=> (res.valid && sum_int_reg == '0 && state_reg == S_IDLE))
        else $error("result load did not restart the region");

    a_flag_matches_total: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.stats_valid == (res.intensity_total != '0)))
        else $error("stats flag disagrees with total");

endmodule

[tb/sv/rwcm_moments_checker.sv]
module rwcm_moments_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rwcm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rwcm_pkg::CFG_DATA_W-1:0] cfg_data,
    rwcm_pix_if                             pix,
    rwcm_res_if                             res,
    output int                              mismatch_count,
    output int                              stats_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rwcm_pkg::*;

    localparam logic [63:0] TOT_MAX     = (64'd1 << TOT_W) - 64'd1;
    localparam logic [63:0] S1_MAX      = (64'd1 << S1_W) - 64'd1;
    localparam logic [63:0] S2_MAX      = {64{1'b1}};
    localparam logic [63:0] MEAN_MAX    = (64'd1 << MEAN_W) - 64'd1;
    localparam logic [63:0] VAR_MAX     = (64'd1 << VAR_W) - 64'd1;

    typedef struct packed {
        logic [TOT_W-1:0]  total;
        logic [MEAN_W-1:0] cen_col;
        logic [MEAN_W-1:0] cen_row;
        logic [VAR_W-1:0]  spread_col;
        logic [VAR_W-1:0]  spread_row;
        logic              valid_flag;
    } region_stats_t;

    // programmed registers
    logic [PIX_W-1:0] bg_level;
    logic             mask_on;
    logic [LAB_W-1:0] want_label;
    logic [ROI_W-1:0] col_lo;
    logic [ROI_W-1:0] col_hi;
    logic [ROI_W-1:0] row_lo;
    logic [ROI_W-1:0] row_hi;

    // scan position and moment sums
    logic [ROI_W-1:0] cur_col;
    logic [ROI_W-1:0] cur_row;
    logic [63:0]      acc_w;
    logic [63:0]      acc_xw;
    logic [63:0]      acc_yw;
    logic [63:0]      acc_xxw;
    logic [63:0]      acc_yyw;

    region_stats_t expected_stats[$];

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] maxv);
        logic [64:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return (sum > {1'b0, maxv}) ? maxv : sum[63:0];
    endfunction

    // floor(256 * num / den)
    function automatic logic [63:0] q8_ratio(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = num / den;
        rem = num % den;
        if (quo > (S2_MAX >> FRAC_W))
            return S2_MAX;
        return (quo << FRAC_W) + ((rem << FRAC_W) / den);
    endfunction

    function automatic void axis_moments(input logic [63:0] s1, input logic [63:0] s2,
                                         input logic [63:0] tot,
                                         output logic [MEAN_W-1:0] mean,
                                         output logic [VAR_W-1:0] spread);
        logic [63:0] m;
        logic [63:0] m2;
        logic [63:0] sq;
        m = q8_ratio(s1, tot);
        if (m > MEAN_MAX)
            m = MEAN_MAX;
        m2 = q8_ratio(s2, tot);
        sq = (m * m) >> FRAC_W;
        m2 = (m2 > sq) ? m2 - sq : 64'd0;
        if (m2 > VAR_MAX)
            m2 = VAR_MAX;
        mean = m[MEAN_W-1:0];
        spread = m2[VAR_W-1:0];
    endfunction

    task automatic restart_region();
        cur_col = col_lo;
        cur_row = row_lo;
        acc_w   = '0;
        acc_xw  = '0;
        acc_yw  = '0;
        acc_xxw = '0;
        acc_yyw = '0;
    endtask

    task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_BACKGROUND: bg_level = data[PIX_W-1:0];
            REG_USE_MASK:   mask_on = data[0];
            REG_TARGET:     want_label = data[LAB_W-1:0];
            REG_COL_MIN:
            begin
                col_lo = data[ROI_W-1:0];
                restart_region();
            end
            REG_COL_MAX:
            begin
                col_hi = data[ROI_W-1:0];
                restart_region();
            end
            REG_ROW_MIN:
            begin
                row_lo = data[ROI_W-1:0];
                restart_region();
            end
            REG_ROW_MAX:
            begin
                row_hi = data[ROI_W-1:0];
                restart_region();
            end
            default: ;
        endcase
    endtask

    task automatic take_pixel(input logic [PIX_W-1:0] value, input logic [LAB_W-1:0] label);
        logic          counted;
        logic          row_done;
        logic [63:0]   w;
        logic [63:0]   xw;
        logic [63:0]   yw;
        region_stats_t st;
        counted = (!mask_on || label[LABEL_BITS-1:0] == want_label[LABEL_BITS-1:0])
                  && (value[PIXEL_BITS-1:0] > bg_level);
        if (counted)
        begin
            w  = 64'(value[PIXEL_BITS-1:0]) - 64'(bg_level);
            xw = 64'(cur_col) * w;
            yw = 64'(cur_row) * w;
            acc_w   = sat_add(acc_w, w, TOT_MAX);
            acc_xw  = sat_add(acc_xw, xw, S1_MAX);
            acc_yw  = sat_add(acc_yw, yw, S1_MAX);
            acc_xxw = sat_add(acc_xxw, xw * 64'(cur_col), S2_MAX);
            acc_yyw = sat_add(acc_yyw, yw * 64'(cur_row), S2_MAX);
        end
        row_done = cur_col >= col_hi;
        if (!(row_done && cur_row >= row_hi))
        begin
            if (row_done)
            begin
                cur_col = col_lo;
                cur_row = cur_row + 1'b1;
            end
            else
                cur_col = cur_col + 1'b1;
            return;
        end
        st = '0;
        st.total = acc_w[TOT_W-1:0];
        if (acc_w != 0)
        begin
            axis_moments(acc_xw, acc_xxw, acc_w, st.cen_col, st.spread_col);
            axis_moments(acc_yw, acc_yyw, acc_w, st.cen_row, st.spread_row);
            st.valid_flag = 1'b1;
        end
        expected_stats.push_back(st);
        restart_region();
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("%0t: %s mismatch, got %0h expected %0h", $realtime, field, got, want);
    endtask

    task automatic check_result();
        region_stats_t want;
        if (expected_stats.size() == 0)
        begin
            report_mismatch("unrequested result, intensity_total", res.intensity_total, 0);
            return;
        end
        want = expected_stats.pop_front();
        if (res.intensity_total !== want.total)
            report_mismatch("intensity_total", res.intensity_total, want.total);
        if (res.centroid_col !== want.cen_col)
            report_mismatch("centroid_col", res.centroid_col, want.cen_col);
        if (res.centroid_row !== want.cen_row)
            report_mismatch("centroid_row", res.centroid_row, want.cen_row);
        if (res.variance_col !== want.spread_col)
            report_mismatch("variance_col", res.variance_col, want.spread_col);
        if (res.variance_row !== want.spread_row)
            report_mismatch("variance_row", res.variance_row, want.spread_row);
        if (res.stats_valid !== want.valid_flag)
            report_mismatch("stats_valid", res.stats_valid, want.valid_flag);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_level   = '0;
            mask_on    = 1'b0;
            want_label = '0;
            col_lo     = '0;
            col_hi     = '0;
            row_lo     = '0;
            row_hi     = '0;
            restart_region();
            expected_stats.delete();
            mismatch_count = 0;
            stats_pending  = 0;
        end
        else
        begin
            // an older result may leave while a new region closes
            if (res.valid && res.ready)
                check_result();
            if (cfg_we)
                apply_reg_write(cfg_index, cfg_data);
            if (pix.valid && pix.ready)
                take_pixel(pix.pixel_value, pix.pixel_label);
            stats_pending = expected_stats.size();
        end
    end

endmodule

[tb/sv/tb_roi_weighted_centroid_moments_unit.sv]
module tb_roi_weighted_centroid_moments_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import rwcm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    localparam int SETTLE_CYCLES  = 16;
    localparam int TAIL_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TOTAL_PIXELS   = 1320;
    localparam int PAD_W          = CFG_DATA_W - ROI_W;
    localparam int ROI_SPAN       = 1 << ROI_W;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatch_count;
    int stats_pending;
    int src_idle_pct;
    int snk_stall_pct;
    int pixels_sent;

    // shadow of the programmed region, used to size requests
    logic [PIX_W-1:0] bg_level;
    logic             mask_on;
    logic [LAB_W-1:0] match_label;
    logic [ROI_W-1:0] col_lo;
    logic [ROI_W-1:0] col_hi;
    logic [ROI_W-1:0] row_lo;
    logic [ROI_W-1:0] row_hi;

    rwcm_pix_if pix ();
    rwcm_res_if res ();

    roi_weighted_centroid_moments_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix       (pix),
        .res       (res)
    );

    rwcm_moments_checker moments_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pix            (pix),
        .res            (res),
        .mismatch_count (mismatch_count),
        .stats_pending  (stats_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            res.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (pix.valid && pix.ready) || (res.valid && res.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_BACKGROUND: bg_level = data[PIX_W-1:0];
            REG_USE_MASK:   mask_on = data[0];
            REG_TARGET:     match_label = data[LAB_W-1:0];
            REG_COL_MIN:    col_lo = data[ROI_W-1:0];
            REG_COL_MAX:    col_hi = data[ROI_W-1:0];
            REG_ROW_MIN:    row_lo = data[ROI_W-1:0];
            REG_ROW_MAX:    row_hi = data[ROI_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic push_pixel(input logic [PIX_W-1:0] value, input logic [LAB_W-1:0] label);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            pix.valid <= 1'b0;
            @(posedge clk);
        end
        pix.valid       <= 1'b1;
        pix.pixel_value <= value;
        pix.pixel_label <= label;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        pixels_sent++;
    endtask

    // wait out pending results plus the tail of a counted pixel, then change idling
    task automatic settle(input int idle_pct, input int stall_pct);
        pix.valid <= 1'b0;
        @(negedge clk);
        while (stats_pending != 0)
            @(negedge clk);
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_random_pixel();
        logic [PIX_W-1:0] v;
        logic [LAB_W-1:0] l;
        l = (mask_on && $urandom_range(0, 9) < 7) ? match_label : LAB_W'($urandom);
        case ($urandom_range(0, 9))
            0:       v = PIX_W'($urandom_range(0, bg_level));
            1:       v = bg_level;
            2:       v = '1;
            3:       v = PIX_W'($urandom);
            default: v = PIX_W'($urandom_range(bg_level, (1 << PIX_W) - 1));
        endcase
        push_pixel(v, l);
    endtask

    function automatic void pick_span(input int short_len, input int long_len,
                                      output logic [ROI_W-1:0] lo, output logic [ROI_W-1:0] hi);
        int len;
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(long_len / 2, long_len)
                                           : $urandom_range(1, short_len);
        case ($urandom_range(0, 9))
            0:       lo = '0;
            1:       lo = ROI_W'(ROI_SPAN - len);
            default: lo = ROI_W'($urandom_range(0, ROI_SPAN - len));
        endcase
        hi = lo + ROI_W'(len - 1);
        // minimum above maximum
        if ($urandom_range(0, 9) == 0 && lo != 0)
            hi = ROI_W'($urandom_range(0, lo - 1));
    endfunction

    function automatic int region_pixels();
        int cols;
        int rows;
        cols = (col_hi >= col_lo) ? int'(col_hi) - int'(col_lo) + 1 : 1;
        rows = (row_hi >= row_lo) ? int'(row_hi) - int'(row_lo) + 1 : 1;
        return cols * rows;
    endfunction

    initial
    begin
        int               phase_no;
        int               regions;
        int               count;
        logic [ROI_W-1:0] lo;
        logic [ROI_W-1:0] hi;
        logic [PIX_W-1:0] bg;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        pix.valid       = 1'b0;
        pix.pixel_value = '0;
        pix.pixel_label = '0;
        src_idle_pct    = 0;
        snk_stall_pct   = 0;
        pixels_sent     = 0;
        bg_level        = '0;
        mask_on         = 1'b0;
        match_label     = '0;
        col_lo          = '0;
        col_hi          = '0;
        row_lo          = '0;
        row_hi          = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-pixel regions after reset: empty and full scale
        push_pixel('0, '0);
        push_pixel('1, '1);
        settle(0, 0);

        // unused index is ignored; 2x2 region in the far corner with masking
        set_reg(REG_UNUSED, '1);
        set_reg(REG_BACKGROUND, 16'd100);
        set_reg(REG_USE_MASK, 16'd1);
        set_reg(REG_TARGET, 16'hA5A5);
        set_reg(REG_COL_MIN, 16'd4094);
        set_reg(REG_COL_MAX, 16'hFFFF);
        set_reg(REG_ROW_MIN, 16'hFFFE);
        set_reg(REG_ROW_MAX, 16'd4095);
        push_pixel(16'd101, 16'hA5A5);
        push_pixel(16'd100, 16'hA5A5);
        push_pixel('1, 16'hA5A5);
        push_pixel('1, 16'h5A5A);
        settle(0, 0);

        // a bound write mid-region restarts it, a background write does not
        set_reg(REG_BACKGROUND, 16'd0);
        set_reg(REG_USE_MASK, 16'd0);
        set_reg(REG_COL_MIN, 16'd0);
        set_reg(REG_COL_MAX, 16'd2);
        set_reg(REG_ROW_MIN, 16'd0);
        set_reg(REG_ROW_MAX, 16'd1);
        push_pixel(16'd500, 16'd0);
        push_pixel(16'd600, 16'd0);
        settle(0, 0);
        set_reg(REG_COL_MAX, 16'd2);
        push_pixel(16'd700, 16'd1);
        push_pixel(16'd800, 16'd2);
        push_pixel(16'd0, 16'd3);
        settle(0, 0);
        set_reg(REG_BACKGROUND, 16'd1000);
        push_pixel(16'd1500, 16'd4);
        push_pixel(16'd900, 16'd5);
        push_pixel(16'd40000, 16'd6);
        settle(0, 0);

        // minimum above maximum: one-pixel region, then one-pixel rows
        set_reg(REG_COL_MIN, 16'd10);
        set_reg(REG_COL_MAX, 16'd3);
        set_reg(REG_ROW_MIN, 16'd7);
        set_reg(REG_ROW_MAX, 16'd2);
        push_pixel(16'd2000, 16'd0);
        settle(0, 0);
        set_reg(REG_ROW_MIN, 16'd0);
        set_reg(REG_ROW_MAX, 16'd2);
        push_pixel(16'd3000, 16'd0);
        push_pixel(16'd65000, 16'd0);
        push_pixel(16'd1001, 16'd0);
        settle(0, 0);

        // masking with no matching label leaves the total empty
        set_reg(REG_USE_MASK, 16'd1);
        set_reg(REG_TARGET, 16'd0);
        push_pixel(16'd30000, 16'd1);
        push_pixel(16'd30000, '1);
        push_pixel(16'd30000, 16'h8000);

        phase_no = 0;
        while (pixels_sent < TOTAL_PIXELS)
        begin
            case (phase_no % 4)
                0: settle(0, 0);
                1: settle(65, 0);
                2: settle(0, 65);
                default: settle(23, 23);
            endcase
            case ($urandom_range(0, 7))
                0:       bg = '0;
                1:       bg = '1;
                2, 3:    bg = PIX_W'($urandom_range(0, 255));
                default: bg = PIX_W'($urandom);
            endcase
            if ($urandom_range(0, 3) == 0)
                set_reg(REG_UNUSED, CFG_DATA_W'($urandom));
            set_reg(REG_BACKGROUND, bg);
            set_reg(REG_USE_MASK, {(CFG_DATA_W-1)'($urandom), 1'($urandom)});
            set_reg(REG_TARGET, ($urandom_range(0, 3) == 0) ? '0 : CFG_DATA_W'($urandom));
            pick_span(6, 64, lo, hi);
            set_reg(REG_COL_MIN, {PAD_W'($urandom), lo});
            set_reg(REG_COL_MAX, {PAD_W'($urandom), hi});
            pick_span(3, 4, lo, hi);
            set_reg(REG_ROW_MIN, {PAD_W'($urandom), lo});
            set_reg(REG_ROW_MAX, {PAD_W'($urandom), hi});

            regions = $urandom_range(2, 6);
            repeat (regions)
            begin
                count = region_pixels();
                repeat (count) send_random_pixel();
            end
            // broken region: cut short, cleared by the next bound writes
            if ($urandom_range(0, 5) == 0)
            begin
                count = $urandom_range(1, 5);
                repeat (count) send_random_pixel();
            end
            phase_no++;
        end

        pix.valid <= 1'b0;
        @(negedge clk);
        while (stats_pending != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
